### hw/rtl/cc3_pkg.sv
// Shared types and constants for the 3x3 RGB convolution block.
// Depends on nothing; used by the window cells, the MAC pipe and the top level.
`timescale 1ns / 1ps

package cc3_pkg;

    // Pixel and field widths
    localparam int PIX_W       = 8;
    localparam int CH_N        = 3;
    localparam int RGB_W       = PIX_W * CH_N;
    localparam int TAPS        = 9;
    localparam int COEF_W      = 16;
    localparam int COEF_FRAC   = 12;
    localparam int KROW_W      = 3 * COEF_W;
    localparam int OCOL_W      = 10;
    localparam int ROW_W       = 16;
    localparam int IMGW_W      = 11;

    // Stream and configuration port widths
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 56;
    localparam int PAD_W       = OUT_TDATA_W - RGB_W - OCOL_W - ROW_W;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 48;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_TOP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_MID   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_BOT   = 3'd4;

    // One channel, one RGB pixel (red lowest)
    typedef logic [PIX_W-1:0] t_chan;
    typedef t_chan [CH_N-1:0] t_rgb;

    // One window column: [0] two rows above, [1] row above, [2] current row
    typedef t_rgb [2:0] t_wcol;

    // Row or column map of the three kernel taps into the window
    typedef logic [2:0][1:0] t_sel3;

    // Nine selected taps, index row * 3 + column
    typedef t_rgb [TAPS-1:0] t_taps;

    // Sideband of one result
    typedef struct packed {
        logic [OCOL_W-1:0] col;
        logic [ROW_W-1:0]  row;
        logic              last;
        logic              eof;
    } t_meta;

endpackage

### hw/rtl/cc3_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Read returns the old contents when the same address is written in that cycle.
`timescale 1ns / 1ps

module cc3_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    // Write when enabled, read every cycle
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_q <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_q;

endmodule

### hw/rtl/cc3_wcell.sv
// Window cell: holds one column of three RGB pixels and hands it to its left
// neighbor on every accepted pixel. Picks the three row taps. Uses cc3_pkg.
`timescale 1ns / 1ps

module cc3_wcell (
    input  logic           i_clk,
    input  logic           i_shift,
    input  cc3_pkg::t_wcol i_col,
    input  cc3_pkg::t_sel3 i_row_sel,
    output cc3_pkg::t_wcol o_taps,
    output cc3_pkg::t_wcol o_col
);

    cc3_pkg::t_wcol r_col;

    // Advance the column on each accepted pixel
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_col <= i_col;
        end
    end

    // Replicate the edge rows through the row map
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            o_taps[k] = r_col[i_row_sel[k]];
        end
    end

    assign o_col = r_col;

endmodule

### hw/rtl/cc3_mac.sv
// Three-stage multiply-accumulate pipe: nine pixel taps per channel times signed Q4.12
// coefficients, row sums, rounding and clamping into the output register. Uses cc3_pkg.
`timescale 1ns / 1ps

module cc3_mac (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_valid,
    output logic                                         o_ready,
    input  cc3_pkg::t_taps                               i_taps,
    input  cc3_pkg::t_meta                               i_meta,
    input  logic [cc3_pkg::TAPS*cc3_pkg::COEF_W-1:0]     i_kernel,
    output logic                                         o_valid,
    input  logic                                         i_ready,
    output cc3_pkg::t_rgb                                o_rgb,
    output cc3_pkg::t_meta                               o_meta
);

    localparam int PIX_W   = cc3_pkg::PIX_W;
    localparam int CH_N    = cc3_pkg::CH_N;
    localparam int TAPS    = cc3_pkg::TAPS;
    localparam int COEF_W  = cc3_pkg::COEF_W;
    localparam int FRAC    = cc3_pkg::COEF_FRAC;
    localparam int PROD_W  = COEF_W + PIX_W;
    localparam int RSUM_W  = PROD_W + 2;
    localparam int ACC_W   = RSUM_W + 2;

    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic w_en1;
    logic w_en2;
    logic w_en3;

    logic signed [PROD_W:0]     w_full [CH_N][TAPS];
    logic signed [PROD_W-1:0]   r_prod [CH_N][TAPS];
    logic signed [RSUM_W-1:0]   r_rsum [CH_N][3];
    cc3_pkg::t_meta             r_m1;
    cc3_pkg::t_meta             r_m2;
    cc3_pkg::t_meta             r_m3;
    cc3_pkg::t_rgb              r_rgb;

    // Round half up, then clamp to the pixel range
    function automatic logic [PIX_W-1:0] f_round_clamp(input logic signed [ACC_W-1:0] s);
        logic [PIX_W-1:0] q;
        if (s[ACC_W-1] || s == '0) begin
            q = '0;
        end else if (s[ACC_W-2:FRAC+PIX_W] != '0) begin
            q = '1;
        end else begin
            q = s[FRAC+PIX_W-1:FRAC];
        end
        return q;
    endfunction

    // Stage enables: a stage loads when empty or when it drains forward
    assign w_en3   = !r_v3 || i_ready;
    assign w_en2   = !r_v2 || w_en3;
    assign w_en1   = !r_v1 || w_en2;
    assign o_ready = w_en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_en1) begin
                r_v1 <= i_valid;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
            if (w_en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // Multiply each tap by its coefficient
    always_comb begin
        for (int ch = 0; ch < CH_N; ch++) begin
            for (int k = 0; k < TAPS; k++) begin
                w_full[ch][k] = $signed(i_kernel[k*COEF_W +: COEF_W]) *
                                $signed({1'b0, i_taps[k][ch]});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1 && i_valid) begin
            for (int ch = 0; ch < CH_N; ch++) begin
                for (int k = 0; k < TAPS; k++) begin
                    r_prod[ch][k] <= w_full[ch][k][PROD_W-1:0];
                end
            end
            r_m1 <= i_meta;
        end
    end

    // Sum each kernel row
    always_ff @(posedge i_clk) begin
        if (w_en2 && r_v1) begin
            for (int ch = 0; ch < CH_N; ch++) begin
                for (int kr = 0; kr < 3; kr++) begin
                    r_rsum[ch][kr] <= RSUM_W'(r_prod[ch][3*kr])
                                    + RSUM_W'(r_prod[ch][3*kr+1])
                                    + RSUM_W'(r_prod[ch][3*kr+2]);
                end
            end
            r_m2 <= r_m1;
        end
    end

    // Total, round and clamp into the output register
    always_ff @(posedge i_clk) begin
        if (w_en3 && r_v2) begin
            for (int ch = 0; ch < CH_N; ch++) begin
                r_rgb[ch] <= f_round_clamp(ACC_W'(r_rsum[ch][0]) + ACC_W'(r_rsum[ch][1])
                                         + ACC_W'(r_rsum[ch][2]) + ACC_W'(2048));
            end
            r_m3 <= r_m2;
        end
    end

    assign o_valid = r_v3;
    assign o_rgb   = r_rgb;
    assign o_meta  = r_m3;

    // The bottom right pixel closes the run of its input
    a_eof_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && r_m3.eof |-> r_m3.last)
        else $error("end of frame result without last of run");

endmodule

### hw/rtl/conv3x3_clamp_edge_rgb.sv
// Top level of the 3x3 RGB convolution with replicated border and clamped output.
// Depends on cc3_pkg, cc3_ram, cc3_wcell and cc3_mac.
//
//  channel   direction  handshake               payload
//  s_axis    in         tvalid / tready         tdata: red, green, blue
//  m_axis    out        tvalid / tready         tdata: red, green, blue, col, row
//                                               tlast: last of run, tuser: end of frame
//  cfg       in         i_cfg_wr_en (no wait)   i_cfg_index, i_cfg_wdata
//
// One pixel per clock while the MAC pipe is ready and each pixel releases at most one
// result; a pixel on the right edge or on the last row releases two to four, and the
// single MAC issue slot holds s_axis_tready low until the last of them issues. Results
// pass the multiply, row sum and round-and-clamp registers. Reset restores the registers
// to their defaults and empties the pipe; the line buffer is not cleared and needs no
// pass. A stalled m_axis fills the pipe stage by stage and then holds s_axis.
`timescale 1ns / 1ps

module conv3x3_clamp_edge_rgb #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [cc3_pkg::IN_TDATA_W-1:0]      s_axis_tdata,   // red, green, blue
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [cc3_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,   // red, green, blue,
                                                                // out_col, out_row, pad
    output logic                                m_axis_tlast,
    output logic [0:0]                          m_axis_tuser,   // end_of_frame
    input  logic                                i_cfg_wr_en,
    input  logic [cc3_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [cc3_pkg::CFG_DATA_W-1:0]      i_cfg_wdata
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int RGB_W  = cc3_pkg::RGB_W;
    localparam int LB_W   = 2 * RGB_W;
    localparam int ROW_W  = cc3_pkg::ROW_W;
    localparam int OCOL_W = cc3_pkg::OCOL_W;
    localparam int KROW_W = cc3_pkg::KROW_W;
    localparam int IMGW_W = cc3_pkg::IMGW_W;
    localparam int W_RST  = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             has_up;
        logic             last_row;
        logic             has_left;
        logic             last_col;
        logic             r_eq1;
        logic             c_eq1;
    } t_job;

    // Configuration
    logic [COL_W-1:0]   r_w_last;
    logic [ROW_W-1:0]   r_h_last;
    logic [KROW_W-1:0]  r_k_top;
    logic [KROW_W-1:0]  r_k_mid;
    logic [KROW_W-1:0]  r_k_bot;
    logic [COL_W-1:0]   n_w_last;
    logic [ROW_W-1:0]   n_h_last;
    logic [IMGW_W-1:0]  w_cfg_w;
    logic               w_geom_wr;

    // Raster position
    logic [COL_W-1:0]   r_col;
    logic [ROW_W-1:0]   r_row;
    logic [COL_W-1:0]   n_col;
    logic [ROW_W-1:0]   n_row;
    logic               w_at_last_col;
    logic               w_at_last_row;
    logic               w_accept;

    // Line buffer
    logic [LB_W-1:0]    w_ram_q;
    logic [LB_W-1:0]    w_lb_rd;
    logic [LB_W-1:0]    w_lb_wr;
    logic               r_fwd_v;
    logic [LB_W-1:0]    r_fwd_data;
    cc3_pkg::t_rgb      w_pix;
    cc3_pkg::t_rgb      w_above;
    cc3_pkg::t_rgb      w_above2;
    cc3_pkg::t_wcol     w_new_col;

    // Window chain
    cc3_pkg::t_wcol     w_win [3];
    cc3_pkg::t_wcol     w_cell_taps [3];
    cc3_pkg::t_sel3     w_row_sel;
    cc3_pkg::t_sel3     w_col_sel;
    cc3_pkg::t_taps     w_taps;

    // Result sequencing
    logic               r_job_v;
    t_job               r_job;
    t_job               w_new_job;
    logic               w_new_has;
    logic               r_ri;
    logic               r_ci;
    logic               w_row_cur;
    logic               w_col_cur;
    logic               w_pass_end;
    logic               w_last_all;
    logic               w_issue;
    logic               w_mac_ready;
    logic [ROW_W-1:0]   w_out_row;
    logic [COL_W-1:0]   w_out_col;
    cc3_pkg::t_meta     w_meta;

    // MAC output
    logic               w_res_valid;
    cc3_pkg::t_rgb      w_res_rgb;
    cc3_pkg::t_meta     w_res_meta;

    // Decode the geometry writes into last column and last row
    always_comb begin
        w_cfg_w = i_cfg_wdata[IMGW_W-1:0];
        if (w_cfg_w == '0) begin
            n_w_last = '0;
        end else if (int'(w_cfg_w) > MAX_WIDTH) begin
            n_w_last = COL_W'(MAX_WIDTH - 1);
        end else begin
            n_w_last = COL_W'(w_cfg_w - 11'd1);
        end
        if (i_cfg_wdata[ROW_W-1:0] == '0) begin
            n_h_last = '0;
        end else begin
            n_h_last = i_cfg_wdata[ROW_W-1:0] - 16'd1;
        end
    end

    assign w_geom_wr = i_cfg_wr_en && (i_cfg_index == cc3_pkg::CFG_IMAGE_WIDTH ||
                                       i_cfg_index == cc3_pkg::CFG_IMAGE_HEIGHT);

    // Hold the configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_last <= COL_W'(W_RST - 1);
            r_h_last <= '0;
            r_k_top  <= '0;
            r_k_mid  <= 48'd4096;
            r_k_bot  <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                cc3_pkg::CFG_IMAGE_WIDTH:  r_w_last <= n_w_last;
                cc3_pkg::CFG_IMAGE_HEIGHT: r_h_last <= n_h_last;
                cc3_pkg::CFG_KERNEL_TOP:   r_k_top  <= i_cfg_wdata[KROW_W-1:0];
                cc3_pkg::CFG_KERNEL_MID:   r_k_mid  <= i_cfg_wdata[KROW_W-1:0];
                cc3_pkg::CFG_KERNEL_BOT:   r_k_bot  <= i_cfg_wdata[KROW_W-1:0];
                default: ;
            endcase
        end
    end

    // Advance the raster position; a geometry write restarts the frame
    assign w_at_last_col = (r_col == r_w_last);
    assign w_at_last_row = (r_row == r_h_last);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (w_geom_wr) begin
            n_col = '0;
            n_row = '0;
        end else if (w_accept) begin
            if (w_at_last_col) begin
                n_col = '0;
                n_row = w_at_last_row ? '0 : r_row + 16'd1;
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Line buffer: read ahead at the next column, write back the shifted pair
    cc3_ram #(
        .WIDTH (LB_W),
        .DEPTH (MAX_WIDTH)
    ) u_lbuf (
        .i_clk     (i_clk),
        .i_wr_en   (w_accept),
        .i_wr_addr (r_col),
        .i_wr_data (w_lb_wr),
        .i_rd_addr (n_col),
        .o_rd_data (w_ram_q)
    );

    // Forward a write that hit the address read in the same cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_v <= 1'b0;
        end else begin
            r_fwd_v <= w_accept && (r_col == n_col);
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_data <= w_lb_wr;
    end

    assign w_lb_rd   = r_fwd_v ? r_fwd_data : w_ram_q;
    assign w_above   = w_lb_rd[RGB_W-1:0];
    assign w_above2  = w_lb_rd[LB_W-1:RGB_W];
    assign w_pix     = s_axis_tdata[RGB_W-1:0];
    assign w_lb_wr   = {w_above, w_pix};
    assign w_new_col = {w_pix, w_above, w_above2};

    // Window chain: the newest column enters at the right
    for (genvar k = 0; k < 3; k++) begin : g_cell
        if (k == 2) begin : g_head
            cc3_wcell u_cell (
                .i_clk     (i_clk),
                .i_shift   (w_accept),
                .i_col     (w_new_col),
                .i_row_sel (w_row_sel),
                .o_taps    (w_cell_taps[k]),
                .o_col     (w_win[k])
            );
        end else begin : g_body
            cc3_wcell u_cell (
                .i_clk     (i_clk),
                .i_shift   (w_accept),
                .i_col     (w_win[k+1]),
                .i_row_sel (w_row_sel),
                .o_taps    (w_cell_taps[k]),
                .o_col     (w_win[k])
            );
        end
    end

    // Describe the results that the incoming pixel releases
    always_comb begin
        w_new_job.row      = r_row;
        w_new_job.col      = r_col;
        w_new_job.has_up   = (r_row != '0);
        w_new_job.last_row = w_at_last_row;
        w_new_job.has_left = (r_col != '0);
        w_new_job.last_col = w_at_last_col;
        w_new_job.r_eq1    = (r_row == 16'd1);
        w_new_job.c_eq1    = (r_col == COL_W'(1));
        w_new_has = (w_new_job.has_up || w_new_job.last_row) &&
                    (w_new_job.has_left || w_new_job.last_col);
    end

    // Pick the current result and its edge maps
    always_comb begin
        w_row_cur  = !r_job.has_up || r_ri;
        w_col_cur  = !r_job.has_left || r_ci;
        w_pass_end = !(r_job.has_left && r_job.last_col) || r_ci;
        w_last_all = w_pass_end && (!(r_job.has_up && r_job.last_row) || r_ri);

        if (w_row_cur) begin
            w_row_sel = {2'd2, 2'd2, (r_job.has_up ? 2'd1 : 2'd2)};
        end else begin
            w_row_sel = {2'd2, 2'd1, (r_job.r_eq1 ? 2'd1 : 2'd0)};
        end
        if (w_col_cur) begin
            w_col_sel = {2'd2, 2'd2, (r_job.has_left ? 2'd1 : 2'd2)};
        end else begin
            w_col_sel = {2'd2, 2'd1, (r_job.c_eq1 ? 2'd1 : 2'd0)};
        end

        for (int kr = 0; kr < 3; kr++) begin
            for (int kc = 0; kc < 3; kc++) begin
                w_taps[3*kr+kc] = w_cell_taps[w_col_sel[kc]][kr];
            end
        end

        w_out_row   = w_row_cur ? r_job.row : r_job.row - 16'd1;
        w_out_col   = w_col_cur ? r_job.col : r_job.col - COL_W'(1);
        w_meta.col  = OCOL_W'(w_out_col);
        w_meta.row  = w_out_row;
        w_meta.last = w_last_all;
        w_meta.eof  = w_row_cur && r_job.last_row && w_col_cur && r_job.last_col;
    end

    assign w_issue       = r_job_v && w_mac_ready;
    assign s_axis_tready = !r_job_v || (w_issue && w_last_all);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // Step through the rows and columns of the pending pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_v <= 1'b0;
            r_ri    <= 1'b0;
            r_ci    <= 1'b0;
        end else if (w_accept) begin
            r_job_v <= w_new_has;
            r_ri    <= 1'b0;
            r_ci    <= 1'b0;
        end else if (w_issue) begin
            if (w_last_all) begin
                r_job_v <= 1'b0;
                r_ri    <= 1'b0;
                r_ci    <= 1'b0;
            end else if (w_pass_end) begin
                r_ri    <= 1'b1;
                r_ci    <= 1'b0;
            end else begin
                r_ci    <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_job <= w_new_job;
        end
    end

    // Arithmetic pipe with the output register
    cc3_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_job_v),
        .o_ready  (w_mac_ready),
        .i_taps   (w_taps),
        .i_meta   (w_meta),
        .i_kernel ({r_k_bot, r_k_mid, r_k_top}),
        .o_valid  (w_res_valid),
        .i_ready  (m_axis_tready),
        .o_rgb    (w_res_rgb),
        .o_meta   (w_res_meta)
    );

    assign m_axis_tvalid = w_res_valid;
    assign m_axis_tdata  = {{cc3_pkg::PAD_W{1'b0}}, w_res_meta.row, w_res_meta.col, w_res_rgb};
    assign m_axis_tlast  = w_res_meta.last;
    assign m_axis_tuser  = w_res_meta.eof;

    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= r_w_last)
        else $error("column count beyond the last column");

    a_row_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= r_h_last)
        else $error("row count beyond the last row");

    a_fwd_after_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd_v |-> $past(w_accept))
        else $error("line buffer forward without a write");

    a_second_col_only_on_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_job_v && r_ci |-> r_job.has_left && r_job.last_col)
        else $error("second column step on a pixel off the right edge");

endmodule
